FILE: src/pfc_pkg.sv
// Shared types, format codes and constants of the pixel format converter.
// No dependencies; every other file of the block depends on this package.
package pfc_pkg;

    localparam int FMT_W   = 3;
    localparam int TGT_W   = 4;
    localparam int IDX_W   = 2;
    localparam int DATA_W  = 4;
    localparam int PIX_W   = 32;
    localparam int NB_W    = 3;

    // format codes
    localparam logic [FMT_W-1:0] FMT_I8       = 3'd0;
    localparam logic [FMT_W-1:0] FMT_AI88     = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB888   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_RGBA8888 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd4;
    localparam logic [FMT_W-1:0] FMT_A8       = 3'd5;
    localparam logic [FMT_W-1:0] FMT_RGBA4444 = 3'd6;
    localparam logic [FMT_W-1:0] FMT_RGB5A1   = 3'd7;
    localparam logic [TGT_W-1:0] FMT_AUTO     = 4'd8;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [IDX_W-1:0] REG_TARGET_FORMAT = 2'd1;

    // bit t set: a source of this code converts to target t
    localparam logic [7:0] ALLOWED_TARGETS [4] = '{8'hDE, 8'hFD, 8'hDB, 8'hF7};

    // valid bytes of each format
    localparam logic [NB_W-1:0] BYTES_OF_FORMAT [8] =
        '{3'd1, 3'd2, 3'd3, 3'd4, 3'd2, 3'd1, 3'd2, 3'd2};

    // luma: (299R + 587G + 114B + 500) / 1000 as a multiply by a scaled reciprocal
    localparam int LUMA_SHIFT = 28;
    localparam int LUMA_RECIP = ((1 << LUMA_SHIFT) + 999) / 1000;
    localparam int LUMA_W     = 36;
    localparam logic [LUMA_W-1:0] LUMA_KR = LUMA_W'(299 * LUMA_RECIP);
    localparam logic [LUMA_W-1:0] LUMA_KG = LUMA_W'(587 * LUMA_RECIP);
    localparam logic [LUMA_W-1:0] LUMA_KB = LUMA_W'(114 * LUMA_RECIP);
    localparam logic [LUMA_W-1:0] LUMA_K0 = LUMA_W'(500 * LUMA_RECIP);

    typedef struct packed {
        logic [FMT_W-1:0] source_format;
        logic [TGT_W-1:0] target_format;
    } cfg_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic [NB_W-1:0]  out_bytes;
        logic [FMT_W-1:0] out_format;
        logic             converted;
        logic             last_out;
    } result_t;

endpackage

FILE: src/pfc_if.sv
// Channel interfaces of the pixel format converter: pixel input, result output,
// configuration writes. Depends on pfc_pkg.
interface pfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic       last_pixel;

    modport source (output valid, byte0, byte1, byte2, byte3, last_pixel, input ready);
    modport sink   (input valid, byte0, byte1, byte2, byte3, last_pixel, output ready);
endinterface

interface pfc_out_if;
    logic                     valid;
    logic                     ready;
    logic [pfc_pkg::PIX_W-1:0] out_pixel;
    logic [pfc_pkg::NB_W-1:0]  out_bytes;
    logic [pfc_pkg::FMT_W-1:0] out_format;
    logic                     converted;
    logic                     last_out;

    modport source (output valid, out_pixel, out_bytes, out_format, converted, last_out,
                    input ready);
    modport sink   (input valid, out_pixel, out_bytes, out_format, converted, last_out,
                    output ready);
endinterface

interface pfc_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [pfc_pkg::IDX_W-1:0]  index;
    logic [pfc_pkg::DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/pfc_cfg_regs.sv
// Configuration registers: source and target format.
// Depends on pfc_pkg and pfc_if.
module pfc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    pfc_cfg_if.sink       cfg,
    output pfc_pkg::cfg_t cfg_q
);
    import pfc_pkg::*;

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_format <= FMT_RGBA8888;
            cfg_reg.target_format <= FMT_AUTO;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SOURCE_FORMAT: cfg_reg.source_format <= cfg.data[FMT_W-1:0];
                REG_TARGET_FORMAT: cfg_reg.target_format <= cfg.data;
                default:           cfg_reg <= cfg_reg; // drop writes beyond the list
            endcase
        end
    end

endmodule

FILE: src/pfc_luma.sv
// Luma of an RGB triple, rounded integer (299R+587G+114B+500)/1000.
// Depends on pfc_pkg.
module pfc_luma (
    input  logic [7:0] r,
    input  logic [7:0] g,
    input  logic [7:0] b,
    output logic [7:0] y
);
    import pfc_pkg::*;

    logic [LUMA_W-1:0] acc;

    // constant multiplies fold the divide by 1000 into the weights
    assign acc = ({(LUMA_W-8)'(0), r} * LUMA_KR)
               + ({(LUMA_W-8)'(0), g} * LUMA_KG)
               + ({(LUMA_W-8)'(0), b} * LUMA_KB)
               + LUMA_K0;

    assign y = acc[LUMA_SHIFT+7:LUMA_SHIFT];

endmodule

FILE: src/pfc_convert.sv
// Conversion datapath: one pixel in, one result out, combinational.
// Depends on pfc_pkg and pfc_luma.
module pfc_convert (
    input  pfc_pkg::cfg_t    cfg_q,
    input  pfc_pkg::pixel_t  pix,
    output pfc_pkg::result_t res
);
    import pfc_pkg::*;

    logic       conv_ok;
    logic [7:0] r, g, b, a, y;
    logic [PIX_W-1:0] all_bytes;

    always_comb
    begin
        conv_ok = 1'b0;
        if ((cfg_q.source_format inside {[FMT_I8:FMT_RGBA8888]}) && !cfg_q.target_format[3])
            conv_ok = ALLOWED_TARGETS[cfg_q.source_format[1:0]][cfg_q.target_format[2:0]];
    end

    // expand the source to RGBA
    always_comb
    begin
        r = pix.byte0;
        case (cfg_q.source_format)
            FMT_I8:
            begin
                g = pix.byte0; b = pix.byte0; a = 8'hFF;
            end
            FMT_AI88:
            begin
                g = pix.byte0; b = pix.byte0; a = pix.byte1;
            end
            FMT_RGB888:
            begin
                g = pix.byte1; b = pix.byte2; a = 8'hFF;
            end
            default:
            begin
                g = pix.byte1; b = pix.byte2; a = pix.byte3;
            end
        endcase
    end

    pfc_luma u_luma (
        .r (r),
        .g (g),
        .b (b),
        .y (y)
    );

    assign all_bytes = {pix.byte3, pix.byte2, pix.byte1, pix.byte0};

    always_comb
    begin
        res.last_out = pix.last_pixel;
        if (conv_ok)
        begin
            res.converted  = 1'b1;
            res.out_format = cfg_q.target_format[2:0];
            case (cfg_q.target_format[2:0])
                FMT_I8:
                begin
                    res.out_pixel = {24'd0, y};
                    res.out_bytes = 3'd1;
                end
                FMT_AI88:
                begin
                    res.out_pixel = {16'd0, a, y};
                    res.out_bytes = 3'd2;
                end
                FMT_RGB888:
                begin
                    res.out_pixel = {8'd0, b, g, r};
                    res.out_bytes = 3'd3;
                end
                FMT_RGBA8888:
                begin
                    res.out_pixel = {a, b, g, r};
                    res.out_bytes = 3'd4;
                end
                FMT_RGB565:
                begin
                    res.out_pixel = {16'd0, r[7:3], g[7:2], b[7:3]};
                    res.out_bytes = 3'd2;
                end
                FMT_A8:
                begin
                    res.out_pixel = {24'd0, a};
                    res.out_bytes = 3'd1;
                end
                FMT_RGBA4444:
                begin
                    res.out_pixel = {16'd0, r[7:4], g[7:4], b[7:4], a[7:4]};
                    res.out_bytes = 3'd2;
                end
                default: // RGB5A1
                begin
                    res.out_pixel = {16'd0, r[7:3], g[7:3], b[7:3], a[7]};
                    res.out_bytes = 3'd2;
                end
            endcase
        end
        else
        begin
            // pass through, trimmed to the source byte count
            res.converted  = 1'b0;
            res.out_format = cfg_q.source_format;
            res.out_bytes  = BYTES_OF_FORMAT[cfg_q.source_format];
            case (res.out_bytes)
                3'd1:    res.out_pixel = {24'd0, all_bytes[7:0]};
                3'd2:    res.out_pixel = {16'd0, all_bytes[15:0]};
                3'd3:    res.out_pixel = {8'd0, all_bytes[23:0]};
                default: res.out_pixel = all_bytes;
            endcase
        end
    end

endmodule

FILE: src/pixel_format_converter.sv
// Top level of the pixel format converter: input register, conversion logic,
// result register. Depends on pfc_pkg, pfc_if, pfc_cfg_regs and pfc_convert.
//
//  Channel  | Dir | Payload                                              | Transfer
//  ---------+-----+------------------------------------------------------+------------------
//  cfg      | in  | index (2 b), data (4 b)                               | valid & ready
//  pixel    | in  | byte0..byte3 (8 b each), last_pixel                   | valid & ready
//  result   | out | out_pixel (32), out_bytes, out_format, converted,     | valid & ready
//           |     | last_out                                              |
//
// One pixel per clock sustained while the result side is ready. A transferred
// pixel passes through the input register, then the result register, and result
// valid rises when the result register loads. The luma weights and the divide by
// 1000 fold into three constant multiplies and three adds between the registers.
// Reset clears both valid flags and loads source RGBA8888, target AUTO.
// A stalled result holds the result register; the input register still takes a
// new pixel whenever it is empty or its contents move on in the same cycle.
module pixel_format_converter (
    input  logic      clk,
    input  logic      rst_n,
    pfc_cfg_if.sink   cfg,
    pfc_in_if.sink    pixel,
    pfc_out_if.source result
);
    import pfc_pkg::*;

    cfg_t    cfg_q;
    pixel_t  pix_reg;
    logic    pix_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    res_valid_reg;
    logic    res_load;
    logic    pix_load;

    pfc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // advance into the result register when it is empty or being drained
    assign res_load    = pix_valid_reg && (!res_valid_reg || result.ready);
    // take a pixel when the input register is empty or moves on this cycle
    assign pixel.ready = !pix_valid_reg || res_load;
    assign pix_load    = pixel.valid && pixel.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (pixel.ready)
        begin
            pix_valid_reg <= pixel.valid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (pix_load)
        begin
            pix_reg.byte0      <= pixel.byte0;
            pix_reg.byte1      <= pixel.byte1;
            pix_reg.byte2      <= pixel.byte2;
            pix_reg.byte3      <= pixel.byte3;
            pix_reg.last_pixel <= pixel.last_pixel;
        end
    end

    pfc_convert u_convert (
        .cfg_q (cfg_q),
        .pix   (pix_reg),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0; // drop after the transfer
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.out_pixel  = res_reg.out_pixel;
    assign result.out_bytes  = res_reg.out_bytes;
    assign result.out_format = res_reg.out_format;
    assign result.converted  = res_reg.converted;
    assign result.last_out   = res_reg.last_out;

endmodule
